>>> hw/rtl/bc1_bc3_block_decoder_macros.svh
// Assertion macros shared by the block decoder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef BC1_BC3_BLOCK_DECODER_MACROS_SVH
`define BC1_BC3_BLOCK_DECODER_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it
`define BCDEC_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset
`define BCDEC_ASSERT(label, prop, msg) \
    `BCDEC_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> hw/rtl/bcdec_pkg.sv
// Shared types, widths and constant-divide helpers for the BC1/BC3 decoder.
// Depends on nothing; imported by every decoder module.
package bcdec_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 40;
    localparam int NUM_CHAN    = 4;
    localparam int NUM_PIX     = 16;

    // One channel's four palette entries, entry 0 in the low byte
    typedef logic [3:0][7:0] chan_pal_t;
    // Full colour palette, [channel][entry]; channel 0 red .. 3 alpha
    typedef logic [NUM_CHAN-1:0][3:0][7:0] rgba_pal_t;
    // BC3 alpha palette, eight entries
    typedef logic [7:0][7:0] alpha_pal_t;

    // Emitter status back to the palette stage
    typedef struct packed {
        logic take;  // item moves into the output register
        logic done;  // last pixel of the block moves
    } emit_stat_t;

    // floor(x/3), x < 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd1366;
        return p[19:12];
    endfunction

    // floor(x/5), x < 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd3277;
        return p[21:14];
    endfunction

    // floor(x/7), x < 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

    // v*255/31 truncated, by reciprocal
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [12:0] x;
        logic [27:0] p;
        x = {v, 8'h00} - 13'(v);
        p = 28'(x) * 28'd8457;
        return p[25:18];
    endfunction

    // v*255/63 truncated, by reciprocal
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] x;
        logic [29:0] p;
        x = {v, 8'h00} - 14'(v);
        p = 30'(x) * 30'd16645;
        return p[27:20];
    endfunction

endpackage

>>> hw/rtl/bc1_bc3_block_decoder.sv
// BC1 / BC3 block decoder top level: input, endpoint and palette stages.
// Depends on bcdec_pkg, bcdec_color_lane, bcdec_alpha_lane, bcdec_pixel_emit.
//
// Takes one compressed 4x4 block per item and returns its sixteen RGBA8888
// pixels in raster order, one pixel item per cycle while m_tready is high,
// the sixteenth with m_tlast set. Blocks stream back to back with no gap
// as long as m_tready stays high. The first pixel of a block passes the
// endpoint registers (expanded as the block is taken), then the palette
// lanes, then the output register. One further block is held in the
// endpoint stage while one is being emitted.
// format_bc3 is written through cfg_valid/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module bc1_bc3_block_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: bit 0 format_bc3
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bits 63:0 color_block, 127:64 alpha_block
    input  logic [bcdec_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bits 31:0 pixel_rgba, 35:32 pixel_index, 39:36 zero
    output logic [bcdec_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast
);
    import bcdec_pkg::*;

    // configuration register
    logic format_bc3_reg;
    logic format_bc3_next;

    // endpoint stage
    logic                         ep_valid_reg;
    logic                         ep_valid_next;
    logic                         ep_four_reg;
    logic [NUM_CHAN-2:0][7:0]     ep_end0_reg;
    logic [NUM_CHAN-2:0][7:0]     ep_end1_reg;
    logic [31:0]                  ep_cidx_reg;
    logic [63:0]                  ep_ablk_reg;
    logic                         ep_bc3_reg;

    // palette stage
    logic        pal_valid_reg;
    logic        pal_valid_next;
    logic [31:0] pal_cidx_reg;
    logic [47:0] pal_aidx_reg;
    logic        pal_bc3_reg;

    logic        s_accept;
    logic        pal_load;
    logic        pal_free;
    logic [15:0] e0_raw;
    logic [15:0] e1_raw;
    rgba_pal_t   pal;
    alpha_pal_t  alpha_pal;
    emit_stat_t  stat;

    assign cfg_ready = 1'b1;
    assign e0_raw    = s_tdata[15:0];
    assign e1_raw    = s_tdata[31:16];

    // stage handshakes
    always_comb begin
        pal_free        = !pal_valid_reg || stat.done;
        pal_load        = ep_valid_reg && pal_free;
        s_tready        = !ep_valid_reg || pal_load;
        s_accept        = s_tvalid && s_tready;
        ep_valid_next   = s_accept ? 1'b1 : (pal_load ? 1'b0 : ep_valid_reg);
        pal_valid_next  = pal_load ? 1'b1 : (stat.done ? 1'b0 : pal_valid_reg);
        format_bc3_next = (cfg_valid && cfg_ready) ? cfg_data : format_bc3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_bc3_reg <= 1'b0;
            ep_valid_reg   <= 1'b0;
            pal_valid_reg  <= 1'b0;
        end else begin
            format_bc3_reg <= format_bc3_next;
            ep_valid_reg   <= ep_valid_next;
            pal_valid_reg  <= pal_valid_next;
        end
    end

    // endpoint expansion from RGB565
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ep_end0_reg[0] <= expand5(e0_raw[15:11]);
            ep_end0_reg[1] <= expand6(e0_raw[10:5]);
            ep_end0_reg[2] <= expand5(e0_raw[4:0]);
            ep_end1_reg[0] <= expand5(e1_raw[15:11]);
            ep_end1_reg[1] <= expand6(e1_raw[10:5]);
            ep_end1_reg[2] <= expand5(e1_raw[4:0]);
            ep_four_reg    <= format_bc3_reg || (e0_raw > e1_raw);
            ep_cidx_reg    <= s_tdata[63:32];
            ep_ablk_reg    <= s_tdata[127:64];
            ep_bc3_reg     <= format_bc3_reg;
        end
    end

    // index fields carried alongside the palettes
    always_ff @(posedge aclk) begin
        if (pal_load) begin
            pal_cidx_reg <= ep_cidx_reg;
            pal_aidx_reg <= ep_ablk_reg[63:16];
            pal_bc3_reg  <= ep_bc3_reg;
        end
    end

    // colour lanes: red, green, blue
    for (genvar ch = 0; ch < NUM_CHAN - 1; ch++) begin : g_color
        bcdec_color_lane u_lane (
            .aclk       (aclk),
            .load       (pal_load),
            .end0       (ep_end0_reg[ch]),
            .end1       (ep_end1_reg[ch]),
            .four_color (ep_four_reg),
            .pal        (pal[ch])
        );
    end

    // opaque endpoints give the BC1 alpha channel, zero on transparent black
    bcdec_color_lane u_opacity_lane (
        .aclk       (aclk),
        .load       (pal_load),
        .end0       (8'hFF),
        .end1       (8'hFF),
        .four_color (ep_four_reg),
        .pal        (pal[NUM_CHAN-1])
    );

    bcdec_alpha_lane u_alpha_lane (
        .aclk   (aclk),
        .load   (pal_load),
        .alpha0 (ep_ablk_reg[7:0]),
        .alpha1 (ep_ablk_reg[15:8]),
        .pal    (alpha_pal)
    );

    bcdec_pixel_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pal_valid (pal_valid_reg),
        .pal       (pal),
        .alpha_pal (alpha_pal),
        .cidx      (pal_cidx_reg),
        .aidx      (pal_aidx_reg),
        .bc3       (pal_bc3_reg),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hw/rtl/bcdec_color_lane.sv
// One channel lane of the colour palette: interpolates entry 2 and, in four-colour mode, entry 3.
// Depends on bcdec_pkg.
module bcdec_color_lane (
    input  logic                 aclk,
    input  logic                 load,
    input  logic [7:0]           end0,
    input  logic [7:0]           end1,
    input  logic                 four_color,
    output bcdec_pkg::chan_pal_t pal
);
    import bcdec_pkg::*;

    chan_pal_t  pal_reg;
    logic [9:0] sum_a;
    logic [9:0] sum_b;
    logic [8:0] sum_h;

    // weighted sums for the thirds and the half
    always_comb begin
        sum_a = {1'b0, end0, 1'b0} + {2'b00, end1};
        sum_b = {2'b00, end0} + {1'b0, end1, 1'b0};
        sum_h = {1'b0, end0} + {1'b0, end1};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pal_reg[0] <= end0;
            pal_reg[1] <= end1;
            if (four_color) begin
                pal_reg[2] <= div3(sum_a);
                pal_reg[3] <= div3(sum_b);
            end else begin
                pal_reg[2] <= sum_h[8:1];
                pal_reg[3] <= 8'h00;   // transparent black
            end
        end
    end

    assign pal = pal_reg;

endmodule

>>> hw/rtl/bcdec_alpha_lane.sv
// BC3 alpha palette lane: builds the eight-entry alpha table.
// Depends on bcdec_pkg.
module bcdec_alpha_lane (
    input  logic                  aclk,
    input  logic                  load,
    input  logic [7:0]            alpha0,
    input  logic [7:0]            alpha1,
    output bcdec_pkg::alpha_pal_t pal
);
    import bcdec_pkg::*;

    alpha_pal_t pal_reg;
    alpha_pal_t pal_next;

    // sevenths when alpha0 > alpha1, otherwise fifths plus 0 and 255
    always_comb begin
        pal_next[0] = alpha0;
        pal_next[1] = alpha1;
        for (int k = 2; k < 8; k++) begin
            if (alpha0 > alpha1) begin
                pal_next[k] = div7(11'((8 - k) * alpha0) + 11'((k - 1) * alpha1));
            end else if (k < 6) begin
                pal_next[k] = div5(11'((6 - k) * alpha0) + 11'((k - 1) * alpha1));
            end else if (k == 6) begin
                pal_next[k] = 8'h00;
            end else begin
                pal_next[k] = 8'hFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pal_reg <= pal_next;
        end
    end

    assign pal = pal_reg;

endmodule

>>> hw/rtl/bcdec_pixel_emit.sv
// Merge stage: picks each pixel from the lane palettes, one item per cycle while m_tready is high.
// Depends on bcdec_pkg and the decoder macro header.
`include "bc1_bc3_block_decoder_macros.svh"

module bcdec_pixel_emit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               pal_valid,
    input  bcdec_pkg::rgba_pal_t               pal,
    input  bcdec_pkg::alpha_pal_t              alpha_pal,
    input  logic [31:0]                        cidx,
    input  logic [47:0]                        aidx,
    input  logic                               bc3,
    output bcdec_pkg::emit_stat_t              stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bits 31:0 pixel_rgba, 35:32 pixel_index, 39:36 zero
    output logic [bcdec_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast
);
    import bcdec_pkg::*;

    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] pix_reg;
    logic [3:0]  pidx_reg;
    logic        last_reg;

    logic        take;
    logic        done;
    logic [1:0]  sel_c;
    logic [2:0]  sel_a;
    logic [5:0]  aoff;
    logic [31:0] pix_sel;

    // handshake towards the output register
    always_comb begin
        take = pal_valid && (!valid_reg || m_tready);
        done = take && (cnt_reg == 4'(NUM_PIX - 1));
        cnt_next = take ? cnt_reg + 4'd1 : cnt_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // palette lookup for the current pixel
    always_comb begin
        aoff  = {1'b0, cnt_reg, 1'b0} + {2'b00, cnt_reg};
        sel_c = cidx[{cnt_reg, 1'b0} +: 2];
        sel_a = aidx[aoff +: 3];
        for (int ch = 0; ch < NUM_CHAN - 1; ch++) begin
            pix_sel[8*ch +: 8] = pal[ch][sel_c];
        end
        pix_sel[31:24] = bc3 ? alpha_pal[sel_a] : pal[NUM_CHAN-1][sel_c];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (take) begin
            pix_reg  <= pix_sel;
            pidx_reg <= cnt_reg;
            last_reg <= (cnt_reg == 4'(NUM_PIX - 1));
        end
    end

    assign stat.take = take;
    assign stat.done = done;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {4'h0, pidx_reg, pix_reg};
    assign m_tlast   = last_reg;

    `BCDEC_ASSERT(a_last_on_final_pixel,
        valid_reg |-> (last_reg == (pidx_reg == 4'(NUM_PIX - 1))),
        "last marker not on pixel fifteen")
    `BCDEC_ASSERT(a_count_wraps,
        done |=> (cnt_reg == 4'd0),
        "pixel count not back at zero after block end")
    `BCDEC_ASSERT(a_take_advances,
        take |=> (pidx_reg == $past(cnt_reg)) && (cnt_reg == $past(cnt_reg) + 4'd1),
        "pixel count and emitted index out of step")

endmodule
